@@ hdl/s2c_pkg.sv @@
`timescale 1ns / 1ps

package s2c_pkg;

    // Field widths of the channels
    localparam int RADIUS_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int COORD_W  = 17;

    // Bits of the radius and angle fields that carry meaning
    localparam int RADIUS_BITS = 16;
    localparam int ANGLE_BITS  = 16;

    // CORDIC datapath: Q1.30 x/y and turn-fraction residue, with headroom
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    // Q1.15 trig values span [-1.0, +1.0] inclusive
    localparam int TRIG_W = 17;
    localparam int MAG_W  = 16;

    localparam int PROD1_W = RADIUS_W + MAG_W;
    localparam int PROD2_W = PROD1_W + MAG_W;

    // Largest output magnitude
    localparam int OUT_MAG_W = 16;

    // prep + CORDIC stages + fold + two multiply stages + output stage
    localparam int PIPE_DEPTH = CORDIC_STEPS + 5;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // CORDIC result for one angle, with its quadrant not yet unfolded
    typedef struct packed {
        t_quad                  quad;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
    } t_trig;

endpackage

@@ hdl/s2c_if.sv @@
`timescale 1ns / 1ps

interface s2c_in_if;
    logic                           valid;
    logic                           ready;
    logic [s2c_pkg::RADIUS_W-1:0]   radius;
    logic [s2c_pkg::ANGLE_W-1:0]    polar_angle;
    logic [s2c_pkg::ANGLE_W-1:0]    azimuth_angle;

    modport source (output valid, radius, polar_angle, azimuth_angle, input ready);
    modport sink   (input valid, radius, polar_angle, azimuth_angle, output ready);
endinterface

interface s2c_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [s2c_pkg::COORD_W-1:0]  x_coord;
    logic signed [s2c_pkg::COORD_W-1:0]  y_coord;
    logic signed [s2c_pkg::COORD_W-1:0]  z_coord;

    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

@@ hdl/s2c_cordic.sv @@
`timescale 1ns / 1ps

module s2c_cordic (
    input  logic                            i_clk,
    input  logic                            i_adv,
    input  logic [s2c_pkg::ANGLE_W-1:0]     i_angle,
    output s2c_pkg::t_trig                  o_trig
);

    localparam int STEPS = s2c_pkg::CORDIC_STEPS;
    localparam int CW    = s2c_pkg::CW;
    localparam logic [32:0] ANGLE_MASK = (33'd1 << s2c_pkg::ANGLE_BITS) - 33'd1;

    logic [31:0] a32;

    logic signed [CW-1:0] r_x [0:STEPS];
    logic signed [CW-1:0] r_y [0:STEPS];
    logic signed [CW-1:0] r_z [0:STEPS];
    s2c_pkg::t_quad       r_quad [0:STEPS];

    // Scale the angle to a 32-bit turn fraction
    assign a32 = 32'((33'(i_angle) & ANGLE_MASK) << (32 - s2c_pkg::ANGLE_BITS));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0]    <= s2c_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= CW'(a32[29:0]);
            r_quad[0] <= s2c_pkg::t_quad'(a32[31:30]);
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] atan_k;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;

        assign dx     = r_y[k] >>> k;
        assign dy     = r_x[k] >>> k;
        assign atan_k = CW'(s2c_pkg::ATAN_TURN[k]);

        // Rotate toward zero residue
        always_comb begin
            if (r_z[k] >= 0) begin
                n_x = r_x[k] - dx;
                n_y = r_y[k] + dy;
                n_z = r_z[k] - atan_k;
            end else begin
                n_x = r_x[k] + dx;
                n_y = r_y[k] - dy;
                n_z = r_z[k] + atan_k;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_quad[k+1] <= r_quad[k];
            end
        end
    end

    assign o_trig.quad = r_quad[STEPS];
    assign o_trig.x    = r_x[STEPS];
    assign o_trig.y    = r_y[STEPS];

endmodule

@@ hdl/s2c_scale.sv @@
`timescale 1ns / 1ps

module s2c_scale (
    input  logic                                i_clk,
    input  logic                                i_adv,
    input  logic [s2c_pkg::RADIUS_W-1:0]        i_radius,
    input  s2c_pkg::t_trig                      i_polar,
    input  s2c_pkg::t_trig                      i_azim,
    output logic signed [s2c_pkg::COORD_W-1:0]  o_x_coord,
    output logic signed [s2c_pkg::COORD_W-1:0]  o_y_coord,
    output logic signed [s2c_pkg::COORD_W-1:0]  o_z_coord
);

    localparam int CW      = s2c_pkg::CW;
    localparam int TRIG_W  = s2c_pkg::TRIG_W;
    localparam int MAG_W   = s2c_pkg::MAG_W;
    localparam int RW      = s2c_pkg::RADIUS_W;
    localparam int P1W     = s2c_pkg::PROD1_W;
    localparam int P2W     = s2c_pkg::PROD2_W;
    localparam int COORD_W = s2c_pkg::COORD_W;
    localparam logic [32:0] RADIUS_MASK = (33'd1 << s2c_pkg::RADIUS_BITS) - 33'd1;
    localparam logic [P2W-1:0] OUT_MAX = P2W'((1 << s2c_pkg::OUT_MAG_W) - 1);

    typedef struct packed {
        logic               sn_neg;
        logic               cs_neg;
        logic [MAG_W-1:0]   sn_mag;
        logic [MAG_W-1:0]   cs_mag;
    } t_sincos;

    // Round Q1.30 to Q1.15, clamp to +-1.0
    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] lim;
        logic signed [TRIG_W-1:0] res;
        lim = CW'(32768);
        t   = (v + CW'(16384)) >>> 15;
        if (t > lim) begin
            res = TRIG_W'(lim);
        end else if (t < -lim) begin
            res = TRIG_W'(-lim);
        end else begin
            res = TRIG_W'(t);
        end
        return res;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W-1:0] a;
        a = (v < 0) ? -v : v;
        return MAG_W'(a);
    endfunction

    // Unfold the quadrant into signs and magnitudes
    function automatic t_sincos fold(input s2c_pkg::t_trig t);
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] cs;
        logic signed [TRIG_W-1:0] sn;
        t_sincos res;
        c = to_q15(t.x);
        s = to_q15(t.y);
        case (t.quad)
            s2c_pkg::QUAD_0: begin cs = c;  sn = s;  end
            s2c_pkg::QUAD_1: begin cs = -s; sn = c;  end
            s2c_pkg::QUAD_2: begin cs = -c; sn = -s; end
            default:         begin cs = s;  sn = -c; end
        endcase
        res.sn_neg = sn < 0;
        res.cs_neg = cs < 0;
        res.sn_mag = mag(sn);
        res.cs_mag = mag(cs);
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] pack(input logic neg,
                                                       input logic [P2W-1:0] m);
        logic [P2W-1:0] s;
        logic signed [COORD_W-1:0] v;
        s = (m > OUT_MAX) ? OUT_MAX : m;
        v = COORD_W'(s);
        return neg ? -v : v;
    endfunction

    // Fold stage
    logic [RW-1:0]      r_rad;
    t_sincos            r_th;
    t_sincos            r_ph;

    // First multiply stage
    logic [P1W-1:0]     r_rs;
    logic [P1W-1:0]     r_rc;
    logic [MAG_W-1:0]   r_cp_mag;
    logic [MAG_W-1:0]   r_sp_mag;
    logic               r1_x_neg;
    logic               r1_y_neg;
    logic               r1_z_neg;

    // Second multiply stage
    logic [P2W-1:0]     r_px;
    logic [P2W-1:0]     r_py;
    logic [P1W-1:0]     r_pz;
    logic               r2_x_neg;
    logic               r2_y_neg;
    logic               r2_z_neg;

    logic [P2W-1:0]     n_xm;
    logic [P2W-1:0]     n_ym;
    logic [P1W-1:0]     n_zm;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rad <= RW'(33'(i_radius) & RADIUS_MASK);
            r_th  <= fold(i_polar);
            r_ph  <= fold(i_azim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rs     <= P1W'(r_rad) * P1W'(r_th.sn_mag);
            r_rc     <= P1W'(r_rad) * P1W'(r_th.cs_mag);
            r_cp_mag <= r_ph.cs_mag;
            r_sp_mag <= r_ph.sn_mag;
            r1_x_neg <= r_th.sn_neg ^ r_ph.cs_neg;
            r1_y_neg <= r_th.sn_neg ^ r_ph.sn_neg;
            r1_z_neg <= r_th.cs_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px     <= P2W'(r_rs) * P2W'(r_cp_mag);
            r_py     <= P2W'(r_rs) * P2W'(r_sp_mag);
            r_pz     <= r_rc;
            r2_x_neg <= r1_x_neg;
            r2_y_neg <= r1_y_neg;
            r2_z_neg <= r1_z_neg;
        end
    end

    // Round half up on magnitudes
    assign n_xm = (r_px + (P2W'(1) << 29)) >> 30;
    assign n_ym = (r_py + (P2W'(1) << 29)) >> 30;
    assign n_zm = (r_pz + (P1W'(1) << 14)) >> 15;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_x_coord <= pack(r2_x_neg, n_xm);
            o_y_coord <= pack(r2_y_neg, n_ym);
            o_z_coord <= pack(r2_z_neg, P2W'(n_zm));
        end
    end

endmodule

@@ hdl/spherical_to_cartesian_unit.sv @@
`timescale 1ns / 1ps

// Beats pass prep, the fully pipelined 24-stage CORDICs, fold, multiply and
// output registers; one beat per cycle while the skid register is empty.
// A stalled output parks one result in a skid register; input stalls after that.
// Reset (synchronous, active low) empties the pipeline and the skid register.

module spherical_to_cartesian_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2c_in_if.sink      i_in,
    s2c_out_if.source   o_out
);

    localparam int DEPTH   = s2c_pkg::PIPE_DEPTH;
    localparam int STEPS   = s2c_pkg::CORDIC_STEPS;
    localparam int RW      = s2c_pkg::RADIUS_W;
    localparam int COORD_W = s2c_pkg::COORD_W;

    // Valid bit per pipeline stage, moving in step with the data
    logic [DEPTH-1:0]           r_vld;
    logic                       r_skid_vld;
    logic signed [COORD_W-1:0]  r_skid_x;
    logic signed [COORD_W-1:0]  r_skid_y;
    logic signed [COORD_W-1:0]  r_skid_z;

    // Radius rides alongside the CORDIC stages
    logic [RW-1:0]              r_rad [0:STEPS];

    logic                       adv;
    s2c_pkg::t_trig             polar_trig;
    s2c_pkg::t_trig             azim_trig;
    logic signed [COORD_W-1:0]  pipe_x;
    logic signed [COORD_W-1:0]  pipe_y;
    logic signed [COORD_W-1:0]  pipe_z;

    // Advance the whole pipeline unless the skid register holds a beat
    assign adv        = !r_skid_vld;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad[0] <= i_in.radius;
            for (int k = 1; k <= STEPS; k++) begin
                r_rad[k] <= r_rad[k-1];
            end
        end
    end

    s2c_cordic u_cordic_polar (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_angle (i_in.polar_angle),
        .o_trig  (polar_trig)
    );

    s2c_cordic u_cordic_azim (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_angle (i_in.azimuth_angle),
        .o_trig  (azim_trig)
    );

    s2c_scale u_scale (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_radius  (r_rad[STEPS]),
        .i_polar   (polar_trig),
        .i_azim    (azim_trig),
        .o_x_coord (pipe_x),
        .o_y_coord (pipe_y),
        .o_z_coord (pipe_z)
    );

    // Catch the last-stage beat when the sink holds off while the pipe moves;
    // drop the parked beat once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[DEPTH-1] && !o_out.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_x <= pipe_x;
            r_skid_y <= pipe_y;
            r_skid_z <= pipe_z;
        end
    end

    // The parked beat is older than the last stage, so it goes out first
    assign o_out.valid   = r_skid_vld || r_vld[DEPTH-1];
    assign o_out.x_coord = r_skid_vld ? r_skid_x : pipe_x;
    assign o_out.y_coord = r_skid_vld ? r_skid_y : pipe_y;
    assign o_out.z_coord = r_skid_vld ? r_skid_z : pipe_z;

endmodule

@@ verif/s2c_checker.sv @@
`timescale 1ns / 1ps

module s2c_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    s2c_in_if       i_pt,
    s2c_out_if      i_xyz,
    output int      o_error_count,
    output int      o_pending
);

    localparam int RADIUS_W    = s2c_pkg::RADIUS_W;
    localparam int ANGLE_W     = s2c_pkg::ANGLE_W;
    localparam int COORD_W     = s2c_pkg::COORD_W;
    localparam int RADIUS_BITS = s2c_pkg::RADIUS_BITS;
    localparam int ANGLE_BITS  = s2c_pkg::ANGLE_BITS;

    typedef struct {
        logic [RADIUS_W-1:0]    radius;
        logic [ANGLE_W-1:0]     theta;
        logic [ANGLE_W-1:0]     phi;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [COORD_W-1:0]     z;
    } t_point;

    // arctan(2^-i) in 2^-32 turn
    localparam longint ARCTAN_TURN [0:23] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C,
        'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
        'h0000028B, 'h00000145, 'h000000A2, 'h00000051
    };
    localparam longint ROT_GAIN = 652032874;

    t_point expected_points [$];
    int     errors = 0;

    function automatic longint round_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32768) r = 32768;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // Rotation-mode CORDIC over the low 30 turn bits, then quadrant unfold
    function automatic void trig_q15(input logic [ANGLE_W-1:0] angle,
                                     output longint sn, output longint cs);
        logic [31:0]    turn;
        s2c_pkg::t_quad q;
        longint         x, y, z, dx, dy, c, s;
        turn = 32'(angle & ANGLE_W'((1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
        q    = s2c_pkg::t_quad'(turn[31:30]);
        z    = longint'(turn[29:0]);
        x    = ROT_GAIN;
        y    = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ARCTAN_TURN[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ARCTAN_TURN[i];
            end
        end
        c = round_q15(x);
        s = round_q15(y);
        case (q)
            s2c_pkg::QUAD_0: begin cs = c;  sn = s;  end
            s2c_pkg::QUAD_1: begin cs = -s; sn = c;  end
            s2c_pkg::QUAD_2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [COORD_W-1:0] signed_coord(bit neg, longint m);
        longint v;
        if (m > 65535) m = 65535;
        v = neg ? -m : m;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_point convert_point(logic [RADIUS_W-1:0] radius,
                                             logic [ANGLE_W-1:0] theta,
                                             logic [ANGLE_W-1:0] phi);
        t_point pt;
        longint st, ct, sp, cp, rr, p;
        trig_q15(theta, st, ct);
        trig_q15(phi, sp, cp);
        rr = longint'(radius & RADIUS_W'((1 << RADIUS_BITS) - 1));
        pt.radius = radius;
        pt.theta  = theta;
        pt.phi    = phi;
        p    = (rr * magnitude(st) * magnitude(cp) + (64'sd1 << 29)) >> 30;
        pt.x = signed_coord(((st < 0) != (cp < 0)) && p != 0, p);
        p    = (rr * magnitude(st) * magnitude(sp) + (64'sd1 << 29)) >> 30;
        pt.y = signed_coord(((st < 0) != (sp < 0)) && p != 0, p);
        p    = (rr * magnitude(ct) + (64'sd1 << 14)) >> 15;
        pt.z = signed_coord(ct < 0 && p != 0, p);
        return pt;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_coord(string name, t_point pt, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
        if (got !== want)
            report($sformatf("%s r=%h theta=%h phi=%h got %0d expected %0d", name,
                   pt.radius, pt.theta, pt.phi, $signed(got), $signed(want)));
    endtask

    always @(posedge i_clk) begin
        t_point pt;
        if (i_rst_n) begin
            if (i_xyz.valid && i_xyz.ready) begin
                if (expected_points.size() == 0) begin
                    report("result beat with no point outstanding");
                end else begin
                    pt = expected_points.pop_front();
                    compare_coord("x", pt, i_xyz.x_coord, pt.x);
                    compare_coord("y", pt, i_xyz.y_coord, pt.y);
                    compare_coord("z", pt, i_xyz.z_coord, pt.z);
                end
            end
            if (i_pt.valid && i_pt.ready)
                expected_points.push_back(
                    convert_point(i_pt.radius, i_pt.polar_angle, i_pt.azimuth_angle));
        end
        o_pending     <= expected_points.size();
        o_error_count <= errors;
    end

endmodule

@@ verif/spherical_to_cartesian_unit_tb.sv @@
`timescale 1ns / 1ps

module spherical_to_cartesian_unit_tb;

    localparam int ANGLE_W  = s2c_pkg::ANGLE_W;
    localparam int RADIUS_W = s2c_pkg::RADIUS_W;

    localparam int RANDOM_POINTS = 1900;
    // Long enough to back the pipeline and skid register up into the input
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 600;
    localparam int DRAIN_CYCLES  = 40;

    // {radius, theta, phi}: zero radius, full radius on every quadrant
    // boundary, angles one step off a boundary, tiny radii for rounding
    localparam logic [47:0] DIRECTED [0:19] = '{
        48'h0000_0000_0000, 48'hFFFF_0000_0000, 48'hFFFF_4000_0000,
        48'hFFFF_4000_4000, 48'hFFFF_4000_8000, 48'hFFFF_4000_C000,
        48'hFFFF_8000_0000, 48'hFFFF_C000_0000, 48'hFFFF_FFFF_FFFF,
        48'h0001_2000_2000, 48'h0080_2000_6000, 48'hFFFF_2000_2000,
        48'hFFFF_6000_A000, 48'h0100_5555_AAAA, 48'hFFFF_0000_3039,
        48'h0000_FFFF_FFFF, 48'hFFFF_3FFF_BFFF, 48'hFFFF_7FFF_8001,
        48'h0002_4000_2000, 48'h8000_E000_E000
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    s2c_in_if  in_ch ();
    s2c_out_if out_ch ();

    int error_count;
    int pending_count;
    int sent_count = 0;
    int burst_left = 0;

    always #2 i_clk = ~i_clk;

    spherical_to_cartesian_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    s2c_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt          (in_ch),
        .i_xyz         (out_ch),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    // Favor quadrant boundaries and their neighbors; the rest is uniform
    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0:       return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
            1:       return ANGLE_W'($urandom_range(0, 3) * 16384);
            default: return ANGLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 7))
            0:       return RADIUS_W'(65535 - $urandom_range(0, 3));
            1:       return RADIUS_W'($urandom_range(0, 3));
            2:       return RADIUS_W'($urandom_range(0, 1023));
            default: return RADIUS_W'($urandom());
        endcase
    endfunction

    // Offer one point and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; inside a burst, keep it high.
    task automatic send_point(logic [RADIUS_W-1:0] radius, logic [ANGLE_W-1:0] theta,
                              logic [ANGLE_W-1:0] phi);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 10);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid         <= 1'b1;
        in_ch.radius        <= radius;
        in_ch.polar_angle   <= theta;
        in_ch.azimuth_angle <= phi;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        sent_count++;
    endtask

    // Stimulus and verdict
    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.radius        <= '0;
        in_ch.polar_angle   <= '0;
        in_ch.azimuth_angle <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_point(DIRECTED[i][47:32], DIRECTED[i][31:16], DIRECTED[i][15:0]);
        repeat (RANDOM_POINTS)
            send_point(pick_radius(), pick_angle(), pick_angle());
        in_ch.valid <= 1'b0;

        // Let the last accepted beat show up in the outstanding count
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: stall in modes of random length (never, light, heavy,
    // coin flip). Once, well into the run, hold off long enough that the
    // pipeline fills and the block must stall its input.
    initial begin
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 150);
                repeat (span) begin
                    case (mode)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= ($urandom_range(0, 7) != 0);
                        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
